/* sv/mtep_pkg.sv */
package mtep_pkg;

  // variable-length quantity limits and chunk header size
  localparam int VLQ_MAX_BYTES = 4;
  localparam int HEADER_BYTES  = 8;

  localparam int PHASE_W = 4;
  localparam int COUNT_W = 3;
  localparam int LEN_W   = 28;

  // parse phases
  localparam logic [PHASE_W-1:0] PH_HDR     = 4'd0;
  localparam logic [PHASE_W-1:0] PH_DELTA   = 4'd1;
  localparam logic [PHASE_W-1:0] PH_STATUS  = 4'd2;
  localparam logic [PHASE_W-1:0] PH_DATA1   = 4'd3;
  localparam logic [PHASE_W-1:0] PH_DATA2   = 4'd4;
  localparam logic [PHASE_W-1:0] PH_MTYPE   = 4'd5;
  localparam logic [PHASE_W-1:0] PH_LEN     = 4'd6;
  localparam logic [PHASE_W-1:0] PH_PAYLOAD = 4'd7;

  // result kinds
  localparam logic [3:0] KIND_META    = 4'd7;
  localparam logic [3:0] KIND_SYSEX   = 4'd8;
  localparam logic [3:0] KIND_PAYLOAD = 4'd9;
  localparam logic [3:0] KIND_ERROR   = 4'd10;

  // error codes
  localparam logic [1:0] ERR_NO_RUNNING = 2'd0;
  localparam logic [1:0] ERR_VLQ_LONG   = 2'd1;
  localparam logic [1:0] ERR_UNDEFINED  = 2'd2;

  // status bytes and fields
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_ESCAPE    = 8'hF7;
  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] META_EOT     = 8'h2F;
  localparam logic [3:0] HI_PROGRAM   = 4'hC;
  localparam logic [3:0] HI_CHAN_PRES = 4'hD;
  localparam logic [3:0] HI_PITCH     = 4'hE;
  localparam logic [3:0] HI_CHAN_BASE = 4'h8;

  typedef struct packed {
    logic [3:0]       kind;
    logic [LEN_W-1:0] delta_time;
    logic [3:0]       channel;
    logic [7:0]       first_value;
    logic [13:0]      second_value;
    logic [LEN_W-1:0] payload_length;
    logic [7:0]       payload_byte;
    logic             last_of_event;
    logic             end_of_track;
    logic [1:0]       error_code;
  } result_t;

endpackage

/* sv/mtep_input_reg.sv */
module mtep_input_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] track_byte,
  input  logic       step,
  output logic       full,
  output logic [7:0] held_byte
);
  import mtep_pkg::*;

  logic accept;

  assign in_stall = full && !step;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (accept) begin
      full <= 1'b1;
    end else if (step) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= track_byte;
    end
  end

endmodule

/* sv/mtep_decoder.sv */
module mtep_decoder (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       byte_in,
  output logic             res_valid,
  output mtep_pkg::result_t res
);
  import mtep_pkg::*;

  logic [PHASE_W-1:0] phase, phase_next;
  logic [COUNT_W-1:0] header_count, header_count_next;
  logic [LEN_W-1:0]   acc, acc_next;
  logic [COUNT_W-1:0] lbc, lbc_next;
  logic [LEN_W-1:0]   held_delta, held_delta_next;
  logic [7:0]         running_status, running_status_next;
  logic               running_valid, running_valid_next;
  logic [7:0]         current_status, current_status_next;
  logic [7:0]         held_first, held_first_next;
  logic [LEN_W-1:0]   remaining, remaining_next;

  logic [6:0]         d7;
  logic [LEN_W-1:0]   acc_shift;
  logic [7:0]         fd_status;
  logic [3:0]         fd_hi;
  logic [3:0]         cs_hi;
  logic               is_eot;
  logic [7:0]         meta_type;
  logic [LEN_W-1:0]   rem_dec;
  logic [COUNT_W-1:0] hc_inc;

  assign d7        = byte_in[6:0];
  assign acc_shift = {acc[LEN_W-8:0], d7};
  assign fd_status = (phase == PH_STATUS) ? running_status : current_status;
  assign fd_hi     = fd_status[7:4];
  assign cs_hi     = current_status[7:4];
  assign is_eot    = (current_status == ST_META) && (held_first == META_EOT);
  assign meta_type = (current_status == ST_META) ? held_first : 8'd0;
  assign rem_dec   = remaining - LEN_W'(1);
  assign hc_inc    = header_count + COUNT_W'(1);

  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    acc_next            = acc;
    lbc_next            = lbc;
    held_delta_next     = held_delta;
    running_status_next = running_status;
    running_valid_next  = running_valid;
    current_status_next = current_status;
    held_first_next     = held_first;
    remaining_next      = remaining;
    res_valid           = 1'b0;
    res                 = '0;

    case (phase)
      PH_DELTA, PH_LEN: begin
        acc_next = acc_shift;
        if (byte_in[7]) begin
          if ((4'(lbc) + 4'd1) >= 4'(VLQ_MAX_BYTES)) begin
            res_valid        = 1'b1;
            res.kind         = KIND_ERROR;
            res.last_of_event = 1'b1;
            res.error_code   = ERR_VLQ_LONG;
            phase_next       = PH_DELTA;
            acc_next         = '0;
            lbc_next         = '0;
          end else begin
            lbc_next = lbc + COUNT_W'(1);
          end
        end else begin
          lbc_next = '0;
          if (phase == PH_DELTA) begin
            held_delta_next = acc_shift;
            acc_next        = '0;
            phase_next      = PH_STATUS;
          end else begin
            remaining_next     = acc_shift;
            res_valid          = 1'b1;
            res.kind           = (current_status == ST_META) ? KIND_META : KIND_SYSEX;
            res.delta_time     = held_delta;
            res.first_value    = meta_type;
            res.payload_length = acc_shift;
            res.last_of_event  = (acc_shift == '0);
            res.end_of_track   = is_eot;
            if (acc_shift == '0) begin
              acc_next = '0;
              if (is_eot) begin
                phase_next          = PH_HDR;
                header_count_next   = '0;
                running_status_next = '0;
                running_valid_next  = 1'b0;
              end else begin
                phase_next = PH_DELTA;
              end
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
      end
      PH_STATUS, PH_DATA1: begin
        if (phase == PH_STATUS && !byte_in[7] && !running_valid) begin
          res_valid         = 1'b1;
          res.kind          = KIND_ERROR;
          res.last_of_event = 1'b1;
          res.error_code    = ERR_NO_RUNNING;
          phase_next        = PH_DELTA;
          acc_next          = '0;
          lbc_next          = '0;
        end else if (phase == PH_DATA1 || !byte_in[7]) begin
          // first data byte, possibly under running status
          current_status_next = fd_status;
          if (fd_hi == HI_PROGRAM || fd_hi == HI_CHAN_PRES) begin
            res_valid         = 1'b1;
            res.kind          = fd_hi - HI_CHAN_BASE;
            res.delta_time    = held_delta;
            res.channel       = fd_status[3:0];
            res.first_value   = {1'b0, d7};
            res.last_of_event = 1'b1;
            phase_next        = PH_DELTA;
            acc_next          = '0;
            lbc_next          = '0;
          end else begin
            held_first_next = {1'b0, d7};
            phase_next      = PH_DATA2;
          end
        end else if (byte_in == ST_META) begin
          current_status_next = byte_in;
          phase_next          = PH_MTYPE;
        end else if (byte_in == ST_SYSEX || byte_in == ST_ESCAPE) begin
          current_status_next = byte_in;
          held_first_next     = '0;
          acc_next            = '0;
          lbc_next            = '0;
          phase_next          = PH_LEN;
        end else if (byte_in >= ST_SYSEX) begin
          res_valid         = 1'b1;
          res.kind          = KIND_ERROR;
          res.last_of_event = 1'b1;
          res.error_code    = ERR_UNDEFINED;
          phase_next        = PH_DELTA;
          acc_next          = '0;
          lbc_next          = '0;
        end else begin
          running_status_next = byte_in;
          running_valid_next  = 1'b1;
          current_status_next = byte_in;
          phase_next          = PH_DATA1;
        end
      end
      PH_DATA2: begin
        res_valid         = 1'b1;
        res.kind          = cs_hi - HI_CHAN_BASE;
        res.delta_time    = held_delta;
        res.channel       = current_status[3:0];
        res.first_value   = held_first;
        res.second_value  = (cs_hi == HI_PITCH) ? {d7, held_first[6:0]} : {7'd0, d7};
        res.last_of_event = 1'b1;
        phase_next        = PH_DELTA;
        acc_next          = '0;
        lbc_next          = '0;
      end
      PH_MTYPE: begin
        held_first_next = byte_in;
        acc_next        = '0;
        lbc_next        = '0;
        phase_next      = PH_LEN;
      end
      PH_PAYLOAD: begin
        remaining_next     = rem_dec;
        res_valid          = 1'b1;
        res.kind           = KIND_PAYLOAD;
        res.delta_time     = held_delta;
        res.first_value    = meta_type;
        res.payload_length = acc;
        res.payload_byte   = byte_in;
        res.last_of_event  = (rem_dec == '0);
        res.end_of_track   = is_eot;
        if (rem_dec == '0) begin
          acc_next = '0;
          lbc_next = '0;
          if (is_eot) begin
            phase_next          = PH_HDR;
            header_count_next   = '0;
            running_status_next = '0;
            running_valid_next  = 1'b0;
          end else begin
            phase_next = PH_DELTA;
          end
        end
      end
      default: begin
        // chunk header bytes, also any phase code with no meaning
        if (hc_inc == '0 || 4'(hc_inc) >= 4'(HEADER_BYTES)) begin
          header_count_next = '0;
          phase_next        = PH_DELTA;
          acc_next          = '0;
          lbc_next          = '0;
        end else begin
          header_count_next = hc_inc;
          phase_next        = PH_HDR;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HDR;
      header_count   <= '0;
      acc            <= '0;
      lbc            <= '0;
      held_delta     <= '0;
      running_status <= '0;
      running_valid  <= 1'b0;
      current_status <= '0;
      held_first     <= '0;
      remaining      <= '0;
    end else if (step) begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      acc            <= acc_next;
      lbc            <= lbc_next;
      held_delta     <= held_delta_next;
      running_status <= running_status_next;
      running_valid  <= running_valid_next;
      current_status <= current_status_next;
      held_first     <= held_first_next;
      remaining      <= remaining_next;
    end
  end

endmodule

/* sv/mtep_result_reg.sv */
module mtep_result_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  mtep_pkg::result_t res_in,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output mtep_pkg::result_t res_out
);
  import mtep_pkg::*;

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

/* sv/midi_track_event_parser.sv */
// midi track event parser
// input channel: one raw byte of a track chunk per request (track_byte),
//   chunk header included; in_valid / in_stall handshake
// output channel: one decoded result per request; kind selects which fields
//   mean something, the rest read as zero; out_valid / out_stall handshake
// each byte gives zero or one result: channel messages come out on their last
//   data byte, meta and sysex give a header result and then one result per
//   payload byte, errors give a single kind 10 result
// path: a taken byte waits in the input register, is parsed by the decoder
//   logic, and its result is registered in the result register
// throughput: one byte per cycle unless out_stall holds a result; the per-byte
//   parser state update is one pass of logic between input and result register
// stall: while out_stall holds a result, the byte in the input register waits
//   and in_stall rises once that register is occupied; nothing is dropped
// reset: clears the handshake registers and the parser state; the block then
//   skips the next eight bytes as the chunk header
module midi_track_event_parser (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       track_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [3:0]                       kind,
  output logic [mtep_pkg::LEN_W-1:0]       delta_time,
  output logic [3:0]                       channel,
  output logic [7:0]                       first_value,
  output logic [13:0]                      second_value,
  output logic [mtep_pkg::LEN_W-1:0]       payload_length,
  output logic [7:0]                       payload_byte,
  output logic                             last_of_event,
  output logic                             end_of_track,
  output logic [1:0]                       error_code
);
  import mtep_pkg::*;

  logic       in_full;
  logic [7:0] held_byte;
  logic       step;
  logic       res_free;
  logic       res_valid;
  result_t    res;
  result_t    res_q;

  // a held byte is parsed whenever the result register can take its result
  assign step = in_full && res_free;

  mtep_input_reg u_input (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .track_byte (track_byte),
    .step       (step),
    .full       (in_full),
    .held_byte  (held_byte)
  );

  mtep_decoder u_decoder (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .byte_in   (held_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  mtep_result_reg u_result (
    .clk       (clk),
    .rst       (rst),
    .load      (step && res_valid),
    .res_in    (res),
    .free      (res_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_q)
  );

  // unpack the registered result onto the field ports
  assign kind           = res_q.kind;
  assign delta_time     = res_q.delta_time;
  assign channel        = res_q.channel;
  assign first_value    = res_q.first_value;
  assign second_value   = res_q.second_value;
  assign payload_length = res_q.payload_length;
  assign payload_byte   = res_q.payload_byte;
  assign last_of_event  = res_q.last_of_event;
  assign end_of_track   = res_q.end_of_track;
  assign error_code     = res_q.error_code;

endmodule

/* dv/midi_track_event_parser_test.sv */
`timescale 1ns / 1ps
module midi_track_event_parser_test;
  import mtep_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 5;
  // longest legal silence is the receiver hold-off below, so this is generous
  localparam int QUIET_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 200;
  localparam int RANDOM_BYTES  = 900;
  localparam int SETTLE_CYCLES = 8;

  // channel message status bytes, channel in the low nibble
  localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
  localparam logic [7:0] ST_NOTE_ON   = 8'h90;
  localparam logic [7:0] ST_KEY_PRES  = 8'hA0;
  localparam logic [7:0] ST_CONTROL   = 8'hB0;
  localparam logic [7:0] ST_PROGRAM   = 8'hC0;
  localparam logic [7:0] ST_CHAN_PRES = 8'hD0;
  localparam logic [7:0] ST_PITCH     = 8'hE0;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       track_byte;
  logic             out_valid;
  logic             out_stall;
  logic [3:0]       kind;
  logic [LEN_W-1:0] delta_time;
  logic [3:0]       channel;
  logic [7:0]       first_value;
  logic [13:0]      second_value;
  logic [LEN_W-1:0] payload_length;
  logic [7:0]       payload_byte;
  logic             last_of_event;
  logic             end_of_track;
  logic [1:0]       error_code;

  // result as seen on the output ports, packed in package order
  result_t seen;
  assign seen = {kind, delta_time, channel, first_value, second_value, payload_length,
                 payload_byte, last_of_event, end_of_track, error_code};

  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_request = 1'b0;
  int quiet_cycles = 0;

  // track parser mirror plus the queue of decoded events still to come out
  class midi_event_scoreboard;
    logic [PHASE_W-1:0] phase;
    logic [COUNT_W-1:0] hdr_seen;
    logic [LEN_W-1:0]   vlq_acc;
    logic [COUNT_W-1:0] vlq_bytes;
    logic [LEN_W-1:0]   delta_ticks;
    logic [7:0]         running_st;
    bit                 running_ok;
    logic [7:0]         status;
    logic [7:0]         held_value;
    logic [LEN_W-1:0]   bytes_left;
    result_t            expected_events[$];
    int                 mismatches;
    int                 parsed_bytes;

    function new();
      phase = PH_HDR;
      hdr_seen = '0;
      vlq_acc = '0;
      vlq_bytes = '0;
      delta_ticks = '0;
      running_st = '0;
      running_ok = 1'b0;
      status = '0;
      held_value = '0;
      bytes_left = '0;
      mismatches = 0;
      parsed_bytes = 0;
    endfunction

    function result_t make_event(logic [3:0] k, logic [LEN_W-1:0] dt, logic [3:0] ch,
                                 logic [7:0] v1, logic [13:0] v2, logic [LEN_W-1:0] plen,
                                 logic [7:0] pb, bit last, bit eot, logic [1:0] err);
      result_t r;
      r.kind = k;
      r.delta_time = dt;
      r.channel = ch;
      r.first_value = v1;
      r.second_value = v2;
      r.payload_length = plen;
      r.payload_byte = pb;
      r.last_of_event = last;
      r.end_of_track = eot;
      r.error_code = err;
      return r;
    endfunction

    // error results restart at a fresh delta time
    function result_t fault(logic [1:0] code);
      phase = PH_DELTA;
      vlq_acc = '0;
      vlq_bytes = '0;
      return make_event(KIND_ERROR, '0, '0, '0, '0, '0, '0, 1'b1, 1'b0, code);
    endfunction

    function void finish_event(bit eot);
      if (eot) begin
        phase = PH_HDR;
        hdr_seen = '0;
        running_st = '0;
        running_ok = 1'b0;
      end else begin
        phase = PH_DELTA;
      end
      vlq_acc = '0;
      vlq_bytes = '0;
    endfunction

    function bit end_marker();
      return status == ST_META && held_value == META_EOT;
    endfunction

    function logic [7:0] meta_type();
      return (status == ST_META) ? held_value : 8'h00;
    endfunction

    // program and channel pressure finish on their only data byte
    function bit first_data(logic [7:0] b, output result_t r);
      logic [3:0] hi;
      hi = status[7:4];
      r = '0;
      if (hi == HI_PROGRAM || hi == HI_CHAN_PRES) begin
        r = make_event(hi - HI_CHAN_BASE, delta_ticks, status[3:0], {1'b0, b[6:0]}, '0, '0,
                       '0, 1'b1, 1'b0, '0);
        finish_event(1'b0);
        return 1'b1;
      end
      held_value = {1'b0, b[6:0]};
      phase = PH_DATA2;
      return 1'b0;
    endfunction

    // one accepted track byte: advance the mirror, queue any decoded event
    function void take_byte(logic [7:0] b);
      result_t     r;
      bit          got;
      bit          eot;
      logic [3:0]  hi;
      logic [13:0] second;
      int          nxt;
      got = 1'b0;
      r = '0;
      if (phase != PH_HDR)
        parsed_bytes++;
      case (phase)
        PH_DELTA, PH_LEN: begin
          vlq_acc = {vlq_acc[LEN_W-8:0], b[6:0]};
          if (b[7]) begin
            if (vlq_bytes + 1 >= VLQ_MAX_BYTES) begin
              r = fault(ERR_VLQ_LONG);
              got = 1'b1;
            end else begin
              vlq_bytes++;
            end
          end else begin
            vlq_bytes = '0;
            if (phase == PH_DELTA) begin
              delta_ticks = vlq_acc;
              vlq_acc = '0;
              phase = PH_STATUS;
            end else begin
              bytes_left = vlq_acc;
              r = make_event((status == ST_META) ? KIND_META : KIND_SYSEX, delta_ticks, '0,
                             meta_type(), '0, bytes_left, '0, bytes_left == 0, end_marker(),
                             '0);
              got = 1'b1;
              if (bytes_left == 0)
                finish_event(end_marker());
              else
                phase = PH_PAYLOAD;
            end
          end
        end
        PH_STATUS: begin
          if (!b[7]) begin
            if (!running_ok) begin
              r = fault(ERR_NO_RUNNING);
              got = 1'b1;
            end else begin
              status = running_st;
              got = first_data(b, r);
            end
          end else if (b == ST_META) begin
            status = b;
            phase = PH_MTYPE;
          end else if (b == ST_SYSEX || b == ST_ESCAPE) begin
            status = b;
            held_value = '0;
            vlq_acc = '0;
            vlq_bytes = '0;
            phase = PH_LEN;
          end else if (b >= ST_SYSEX) begin
            r = fault(ERR_UNDEFINED);
            got = 1'b1;
          end else begin
            running_st = b;
            running_ok = 1'b1;
            status = b;
            phase = PH_DATA1;
          end
        end
        PH_DATA1: got = first_data(b, r);
        PH_DATA2: begin
          hi = status[7:4];
          second = (hi == HI_PITCH) ? {b[6:0], held_value[6:0]} : {7'd0, b[6:0]};
          r = make_event(hi - HI_CHAN_BASE, delta_ticks, status[3:0], held_value, second, '0,
                         '0, 1'b1, 1'b0, '0);
          got = 1'b1;
          finish_event(1'b0);
        end
        PH_MTYPE: begin
          held_value = b;
          vlq_acc = '0;
          vlq_bytes = '0;
          phase = PH_LEN;
        end
        PH_PAYLOAD: begin
          eot = end_marker();
          bytes_left = bytes_left - 1'b1;
          r = make_event(KIND_PAYLOAD, delta_ticks, '0, meta_type(), '0, vlq_acc, b,
                         bytes_left == 0, eot, '0);
          got = 1'b1;
          if (bytes_left == 0)
            finish_event(eot);
        end
        default: begin
          nxt = hdr_seen + 1;
          if (nxt >= HEADER_BYTES) begin
            hdr_seen = '0;
            phase = PH_DELTA;
            vlq_acc = '0;
            vlq_bytes = '0;
          end else begin
            hdr_seen = COUNT_W'(nxt);
            phase = PH_HDR;
          end
        end
      endcase
      if (got)
        expected_events.insert(expected_events.size(), r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] actual);
      if (want !== actual) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, actual);
        mismatches++;
      end
    endfunction

    function void check_event(result_t actual);
      result_t want;
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected result, expected none actual kind %0h", $time,
                 actual.kind);
        mismatches++;
        return;
      end
      want = expected_events.pop_front();
      compare_field("kind", 32'(want.kind), 32'(actual.kind));
      compare_field("delta_time", 32'(want.delta_time), 32'(actual.delta_time));
      compare_field("channel", 32'(want.channel), 32'(actual.channel));
      compare_field("first_value", 32'(want.first_value), 32'(actual.first_value));
      compare_field("second_value", 32'(want.second_value), 32'(actual.second_value));
      compare_field("payload_length", 32'(want.payload_length),
                    32'(actual.payload_length));
      compare_field("payload_byte", 32'(want.payload_byte), 32'(actual.payload_byte));
      compare_field("last_of_event", 32'(want.last_of_event), 32'(actual.last_of_event));
      compare_field("end_of_track", 32'(want.end_of_track), 32'(actual.end_of_track));
      compare_field("error_code", 32'(want.error_code), 32'(actual.error_code));
    endfunction
  endclass

  midi_event_scoreboard scoreboard = new();

  midi_track_event_parser DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .track_byte     (track_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .delta_time     (delta_time),
    .channel        (channel),
    .first_value    (first_value),
    .second_value   (second_value),
    .payload_length (payload_length),
    .payload_byte   (payload_byte),
    .last_of_event  (last_of_event),
    .end_of_track   (end_of_track),
    .error_code     (error_code)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // result side: every accepted result goes against the oldest decoded event
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      scoreboard.check_event(seen);
  end

  // watchdog: too long without any request moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stall per cycle, or one long hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // one request on the byte channel; entered and left just after a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    track_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scoreboard.take_byte(b);
    @(negedge clk);
  endtask

  // variable-length quantity, most significant group first
  task automatic send_vlq(input logic [LEN_W-1:0] value, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--)
      send_byte({i != 0, value[7*i +: 7]});
  endtask

  task automatic send_header(input logic [7:0] fill);
    repeat (HEADER_BYTES) send_byte(fill);
  endtask

  task automatic send_delta();
    int pick;
    int n;
    pick = $urandom_range(99);
    n = (pick < 70) ? 1 : (pick < 90) ? 2 : (pick < 97) ? 3 : 4;
    send_vlq(LEN_W'($urandom_range(0, (1 << (7 * n)) - 1)), n);
  endtask

  // data bytes sometimes carry bit 7, which the parser must drop
  function automatic logic [7:0] data_byte();
    return 8'(($urandom_range(99) < 15) ? $urandom_range(255) : $urandom_range(127));
  endfunction

  task automatic wait_for_results();
    while (scoreboard.expected_events.size() != 0) @(negedge clk);
  endtask

  // sender pause: nothing offered until the result queue has drained
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    wait_for_results();
  endtask

  task automatic set_pacing(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 57; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 57; end
      default: begin send_idle_pct = 11; stall_pct = 11; end
    endcase
  endtask

  // bring the parser to the start of a delta time, whatever it was doing
  task automatic resync();
    logic [7:0] b;
    while (!(scoreboard.phase == PH_DELTA && scoreboard.vlq_bytes == 0)) begin
      case (scoreboard.phase)
        PH_HDR:             b = 8'($urandom_range(255));
        PH_DELTA:           b = 8'h00;
        PH_STATUS:          b = 8'hF4;  // undefined status forces a restart
        PH_DATA1, PH_DATA2: b = 8'($urandom_range(127));
        PH_LEN:             b = (scoreboard.vlq_bytes == 0) ? 8'h00 : 8'h80;
        default:            b = 8'($urandom_range(255));
      endcase
      send_byte(b);
    end
  endtask

  // meta or sysex length plus its payload, mostly short
  task automatic send_payload();
    int n;
    if ($urandom_range(99) < 90) begin
      n = $urandom_range(0, 6);
      send_vlq(LEN_W'(n), 1);
    end else begin
      n = $urandom_range(128, 160);
      send_vlq(LEN_W'(n), 2);
    end
    repeat (n) send_byte(8'($urandom_range(255)));
  endtask

  task automatic send_channel_event();
    logic [7:0] st;
    send_delta();
    if (scoreboard.running_ok && $urandom_range(99) < 30) begin
      // running status: first data byte must stay below 0x80
      st = scoreboard.running_st;
      send_byte(8'($urandom_range(127)));
    end else begin
      st = 8'h80 + 8'($urandom_range(0, 8'h6F));
      send_byte(st);
      send_byte(data_byte());
    end
    if (st[7:4] != HI_PROGRAM && st[7:4] != HI_CHAN_PRES)
      send_byte(data_byte());
  endtask

  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 6)) begin
      b = 8'($urandom_range(255));
      // a length past its first group keeps bit 7, so it ends in the too-long error
      if (scoreboard.phase == PH_LEN && scoreboard.vlq_bytes != 0)
        b[7] = 1'b1;
      send_byte(b);
    end
  endtask

  task automatic directed_tracks();
    logic [7:0] undefined_codes [4] = '{8'hF1, 8'hF6, 8'hF8, 8'hFE};
    send_header(8'h00);
    // data byte before any status
    send_byte(8'h00); send_byte(8'h40);
    send_byte(8'h00); send_byte(ST_NOTE_ON); send_byte(8'h3C); send_byte(8'h64);
    // running status, bit 7 of the data byte is dropped
    send_byte(8'h7F); send_byte(8'h3E); send_byte(8'hFF);
    send_vlq(LEN_W'(128), 2);
    send_byte(ST_NOTE_OFF | 8'h0F); send_byte(8'h00); send_byte(8'h7F);
    send_byte(8'h00); send_byte(ST_KEY_PRES | 8'h03); send_byte(8'h80); send_byte(8'h01);
    send_byte(8'h00); send_byte(ST_CONTROL | 8'h05); send_byte(8'h07); send_byte(8'h64);
    send_byte(8'h00); send_byte(ST_PROGRAM | 8'h09); send_byte(8'hFF);
    send_byte(8'h01); send_byte(8'h10);
    send_byte(8'h00); send_byte(ST_CHAN_PRES | 8'h0A); send_byte(8'h7F);
    // pitch wheel at both ends
    send_byte(8'h00); send_byte(ST_PITCH | 8'h02); send_byte(8'h7F); send_byte(8'h7F);
    send_byte(8'h00); send_byte(ST_PITCH); send_byte(8'h00); send_byte(8'h00);
    // largest delta time, then one group too many
    send_vlq({LEN_W{1'b1}}, 4); send_byte(ST_CONTROL); send_byte(8'h01); send_byte(8'h02);
    repeat (4) send_byte(8'h80);
    foreach (undefined_codes[i]) begin
      send_byte(8'h00); send_byte(undefined_codes[i]);
    end
    send_byte(8'h00); send_byte(ST_META); send_byte(8'h03);
    send_byte(8'h03); send_byte(8'h61); send_byte(8'h80); send_byte(8'hFF);
    send_byte(8'h00); send_byte(ST_META); send_byte(8'h51); send_byte(8'h00);
    send_byte(8'h00); send_byte(ST_META); send_byte(8'hFF); send_byte(8'h01); send_byte(8'h00);
    send_byte(8'h00); send_byte(ST_SYSEX); send_byte(8'h02); send_byte(8'h7E);
    send_byte(ST_ESCAPE);
    send_byte(8'h00); send_byte(ST_ESCAPE); send_byte(8'h01); send_byte(ST_ESCAPE);
    send_byte(8'h00); send_byte(ST_SYSEX); send_byte(8'h00);
    // meta length too long
    send_byte(8'h00); send_byte(ST_META); send_byte(8'h01); repeat (4) send_byte(8'h80);
    // running status survives meta and sysex
    send_byte(8'h00); send_byte(8'h40); send_byte(8'h41);
    // end of track carrying payload, then a new chunk without running status
    send_byte(8'h00); send_byte(ST_META); send_byte(META_EOT);
    send_byte(8'h02); send_byte(8'hAA); send_byte(8'hBB);
    send_header(8'hFF);
    send_byte(8'h00); send_byte(8'h30);
    send_byte(8'h00); send_byte(ST_META); send_byte(META_EOT); send_byte(8'h00);
    send_header(8'h5A);
  endtask

  task automatic random_tracks();
    int start;
    int section;
    int now;
    int pick;
    logic [7:0] b;
    start = scoreboard.parsed_bytes;
    section = -1;
    while (scoreboard.parsed_bytes - start < RANDOM_BYTES) begin
      now = (scoreboard.parsed_bytes - start) * 8 / RANDOM_BYTES;
      if (now != section) begin
        section = now;
        set_pacing(section % 4);
        if (section == 2)
          drain_results();
        if (section == 4)
          hold_request = 1'b1;
      end
      resync();
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_channel_event();
      end else if (pick < 58) begin
        send_delta(); send_byte(ST_META); send_byte(8'($urandom_range(255)));
        send_payload();
      end else if (pick < 66) begin
        send_delta(); send_byte($urandom_range(1) ? ST_SYSEX : ST_ESCAPE);
        send_payload();
      end else if (pick < 71) begin
        // end of track, new header, often a data byte with no status yet
        send_delta(); send_byte(ST_META); send_byte(META_EOT);
        if ($urandom_range(3) == 0) begin
          send_vlq(LEN_W'(2), 1);
          send_byte(8'($urandom_range(255))); send_byte(8'($urandom_range(255)));
        end else begin
          send_vlq(LEN_W'(0), 1);
        end
        resync();
        if ($urandom_range(1)) begin
          send_delta(); send_byte(8'($urandom_range(127)));
        end
      end else if (pick < 78) begin
        send_delta();
        b = 8'($urandom_range(8'hF1, 8'hFE));
        if (b == ST_ESCAPE)
          b = 8'hF8;
        send_byte(b);
      end else if (pick < 82) begin
        send_delta(); send_byte(8'($urandom_range(127)));
      end else if (pick < 88) begin
        if ($urandom_range(1)) begin
          repeat (4) send_byte(8'h80 | 8'($urandom_range(127)));
        end else begin
          send_delta(); send_byte(ST_META); send_byte(8'($urandom_range(255)));
          repeat (4) send_byte(8'h80 | 8'($urandom_range(127)));
        end
      end else begin
        send_noise();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    track_byte = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_pacing(0);
    directed_tracks();
    random_tracks();
    in_valid <= 1'b0;
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (scoreboard.mismatches == 0 && scoreboard.expected_events.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
